### hw/rtl/xbs_pkg.sv
// Shared types, symbols and the CRC-16 byte update for the XMODEM block sender.
package xbs_pkg;

  localparam int BLOCK_BYTES = 128;
  localparam int ADDR_W      = $clog2(BLOCK_BYTES);
  localparam int IDX_W       = $clog2(BLOCK_BYTES + 5);

  localparam logic [7:0] SYM_SOH = 8'h01;
  localparam logic [7:0] SYM_EOT = 8'h04;
  localparam logic [7:0] SYM_ACK = 8'h06;
  localparam logic [7:0] SYM_NAK = 8'h15;
  localparam logic [7:0] SYM_CAN = 8'h18;
  localparam logic [7:0] SYM_C   = 8'h43;
  localparam logic [7:0] SYM_PAD = 8'h1A;

  localparam logic [15:0] CRC_POLY = 16'h1021;

  localparam logic [7:0] RETRY_RESET = 8'd10;
  localparam logic [3:0] EOT_RESET   = 4'd3;

  typedef enum logic [1:0] {
    KIND_FW      = 2'd0,
    KIND_RX      = 2'd1,
    KIND_TIMEOUT = 2'd2,
    KIND_SLOT    = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_BUSY      = 3'd0,
    ST_DONE      = 3'd1,
    ST_CANCELLED = 3'd2,
    ST_NO_HS     = 3'd3,
    ST_BLK_FAIL  = 3'd4,
    ST_EOT_NACK  = 3'd5
  } status_t;

  typedef enum logic {
    REG_RETRY = 1'b0,
    REG_EOT   = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] payload_byte;
    logic       payload_last;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic [7:0] retry_limit;
    logic [3:0] eot_attempts;
  } cfg_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;
    logic [ADDR_W-1:0] raddr;
  } store_req_t;

  function automatic logic [15:0] crc16_update(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] c;
    c = acc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

### hw/rtl/xbs_store.sv
// Block store: one write port and one registered read port.
module xbs_store (
  input  logic              clk,
  input  xbs_pkg::store_req_t req,
  output logic [7:0]        rd_data
);
  import xbs_pkg::*;

  logic [7:0] mem [BLOCK_BYTES];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rd_data <= mem[req.raddr];
  end

endmodule

### hw/rtl/xbs_regs.sv
// APB-style configuration registers for retry limit and EOT attempts.
module xbs_regs (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output xbs_pkg::cfg_t     cfg
);
  import xbs_pkg::*;

  logic     wr_en;
  reg_idx_t idx;

  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[2]);
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.retry_limit  <= RETRY_RESET;
      cfg.eot_attempts <= EOT_RESET;
    end else if (wr_en) begin
      unique case (idx)
        REG_RETRY: cfg.retry_limit  <= pwdata[7:0];
        REG_EOT:   cfg.eot_attempts <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_RETRY: prdata = {24'h0, cfg.retry_limit};
      REG_EOT:   prdata = {28'h0, cfg.eot_attempts};
      default:   prdata = '0;
    endcase
  end

endmodule

### hw/rtl/xbs_ctrl.sv
// Sender state machine, packet byte generation and the result register.
module xbs_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  xbs_pkg::item_t      item,
  input  xbs_pkg::cfg_t       cfg,
  input  logic                out_stall,
  input  logic [7:0]          rd_data,
  output xbs_pkg::store_req_t req,
  output logic                out_valid,
  output logic                tx_valid,
  output logic [7:0]          tx_byte,
  output logic                payload_taken,
  output logic [2:0]          status,
  output logic                crc_selected,
  output logic [7:0]          block_number
);
  import xbs_pkg::*;

  localparam logic [IDX_W-1:0] DATA_END = IDX_W'(BLOCK_BYTES + 3);
  localparam logic [IDX_W-1:0] HDR      = IDX_W'(3);
  localparam logic [7:0]       FULL     = 8'(BLOCK_BYTES);

  typedef enum logic [2:0] {
    PH_HANDSHAKE,
    PH_FILL,
    PH_SEND,
    PH_WAIT,
    PH_EOT_SEND,
    PH_EOT_WAIT,
    PH_HALT
  } phase_t;

  phase_t           phase, phase_next;
  logic             use_crc, use_crc_next;
  logic [7:0]       seq, seq_next;
  logic [7:0]       attempt, attempt_next;
  logic [7:0]       fill, fill_next;
  logic [IDX_W-1:0] send_idx, send_idx_next;
  logic [15:0]      acc, acc_next;
  logic             final_seen, final_seen_next;
  status_t          end_st, end_st_next;

  logic             txv;
  logic [7:0]       txb;
  logic             taken;
  logic [7:0]       att_inc;
  logic             att_lim;
  logic [IDX_W-1:0] last_idx;
  logic [IDX_W-1:0] k;
  logic [IDX_W-1:0] rd_idx;
  logic [7:0]       dbyte;
  logic             is_rx;
  logic             is_rx_or_to;

  always_comb begin
    phase_next      = phase;
    use_crc_next    = use_crc;
    seq_next        = seq;
    attempt_next    = attempt;
    fill_next       = fill;
    send_idx_next   = send_idx;
    acc_next        = acc;
    final_seen_next = final_seen;
    end_st_next     = end_st;
    txv             = 1'b0;
    txb             = 8'h00;
    taken           = 1'b0;
    req.we          = 1'b0;
    req.waddr       = fill[ADDR_W-1:0];
    req.wdata       = item.payload_byte;

    att_inc     = attempt + 8'd1;
    att_lim     = (att_inc >= cfg.retry_limit) || (att_inc == 8'd0);
    last_idx    = use_crc ? DATA_END + IDX_W'(1) : DATA_END;
    k           = send_idx - HDR;
    dbyte       = ({1'b0, k} < {1'b0, fill[IDX_W-1:0]}) && (fill <= FULL) ? rd_data : SYM_PAD;
    is_rx       = (item.kind == KIND_RX);
    is_rx_or_to = is_rx || (item.kind == KIND_TIMEOUT);

    if (fire) begin
      unique case (phase)
        PH_HANDSHAKE: begin
          priority if (is_rx && item.rx_byte == SYM_C) begin
            use_crc_next = 1'b1;
            attempt_next = 8'd0;
            phase_next   = PH_FILL;
          end else if (is_rx && item.rx_byte == SYM_NAK) begin
            use_crc_next = 1'b0;
            attempt_next = 8'd0;
            phase_next   = PH_FILL;
          end else if (is_rx && item.rx_byte == SYM_CAN) begin
            end_st_next = ST_CANCELLED;
            phase_next  = PH_HALT;
          end else if (is_rx_or_to) begin
            attempt_next = att_inc;
            if (att_lim) begin
              end_st_next = ST_NO_HS;
              phase_next  = PH_HALT;
            end
          end else begin
          end
        end
        PH_FILL: begin
          if (item.kind == KIND_FW && fill < FULL) begin
            req.we    = 1'b1;
            fill_next = fill + 8'd1;
            taken     = 1'b1;
            if (item.payload_last) begin
              final_seen_next = 1'b1;
            end
            if (item.payload_last || fill_next >= FULL) begin
              send_idx_next = '0;
              attempt_next  = 8'd0;
              phase_next    = PH_SEND;
            end
          end
        end
        PH_SEND: begin
          if (item.kind == KIND_SLOT) begin
            txv = 1'b1;
            priority if (send_idx == '0) begin
              txb      = SYM_SOH;
              acc_next = 16'h0000;
            end else if (send_idx == IDX_W'(1)) begin
              txb = seq;
            end else if (send_idx == IDX_W'(2)) begin
              txb = ~seq;
            end else if (send_idx < DATA_END) begin
              txb = dbyte;
              if (use_crc) begin
                acc_next = crc16_update(acc, dbyte);
              end else begin
                acc_next = {8'h00, acc[7:0] + dbyte};
              end
            end else if (send_idx == DATA_END && use_crc) begin
              txb = acc[15:8];
            end else begin
              txb = acc[7:0];
            end
            if (send_idx >= last_idx) begin
              send_idx_next = '0;
              phase_next    = PH_WAIT;
            end else begin
              send_idx_next = send_idx + IDX_W'(1);
            end
          end
        end
        PH_WAIT: begin
          priority if (is_rx && item.rx_byte == SYM_ACK) begin
            seq_next      = seq + 8'd1;
            attempt_next  = 8'd0;
            fill_next     = 8'd0;
            send_idx_next = '0;
            phase_next    = final_seen ? PH_EOT_SEND : PH_FILL;
          end else if (is_rx && item.rx_byte == SYM_CAN) begin
            end_st_next = ST_CANCELLED;
            phase_next  = PH_HALT;
          end else if (is_rx_or_to) begin
            attempt_next = att_inc;
            if (att_lim) begin
              end_st_next = ST_BLK_FAIL;
              phase_next  = PH_HALT;
            end else begin
              send_idx_next = '0;
              phase_next    = PH_SEND;
            end
          end else begin
          end
        end
        PH_EOT_SEND: begin
          if (item.kind == KIND_SLOT) begin
            txv          = 1'b1;
            txb          = SYM_EOT;
            attempt_next = att_inc;
            phase_next   = PH_EOT_WAIT;
          end
        end
        PH_EOT_WAIT: begin
          priority if (is_rx && item.rx_byte == SYM_ACK) begin
            end_st_next = ST_DONE;
            phase_next  = PH_HALT;
          end else if (is_rx_or_to) begin
            if (attempt >= {4'h0, cfg.eot_attempts}) begin
              end_st_next = ST_EOT_NACK;
              phase_next  = PH_HALT;
            end else begin
              phase_next = PH_EOT_SEND;
            end
          end else begin
          end
        end
        PH_HALT: begin
        end
        default: begin
        end
      endcase
    end

    rd_idx    = send_idx_next - HDR;
    req.raddr = rd_idx[ADDR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_HANDSHAKE;
      use_crc    <= 1'b0;
      seq        <= 8'd1;
      attempt    <= 8'd0;
      fill       <= 8'd0;
      send_idx   <= '0;
      acc        <= 16'h0000;
      final_seen <= 1'b0;
      end_st     <= ST_BUSY;
      out_valid  <= 1'b0;
    end else begin
      phase      <= phase_next;
      use_crc    <= use_crc_next;
      seq        <= seq_next;
      attempt    <= attempt_next;
      fill       <= fill_next;
      send_idx   <= send_idx_next;
      acc        <= acc_next;
      final_seen <= final_seen_next;
      end_st     <= end_st_next;
      if (fire) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
    if (fire) begin
      tx_valid      <= txv;
      tx_byte       <= txb;
      payload_taken <= taken;
      status        <= end_st_next;
      crc_selected  <= use_crc_next;
      block_number  <= seq_next;
    end
  end

endmodule

### hw/rtl/xmodem_block_sender.sv
// XMODEM block sender top level: input register, control, block store, registers.
//
//   channel  | direction | handshake            | payload
//   ---------+-----------+----------------------+------------------------------------------
//   in       | input     | in_valid / in_stall  | kind, payload_byte, payload_last, rx_byte
//   out      | output    | out_valid / out_stall| tx_valid, tx_byte, payload_taken, status,
//            |           |                      | crc_selected, block_number
//   config   | input     | APB psel / penable   | paddr, pwdata, prdata
//
// One item per cycle while the output is not stalled: an item is held in the
// input register and its result is registered in the output register.
// The block store is read ahead of use, addressed by the next send index.
// Reset is synchronous and clears control state; the store needs no clearing.
// A stalled output holds the input register, which then stalls the input.
module xmodem_block_sender (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  kind,
  input  logic [7:0]  payload_byte,
  input  logic        payload_last,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        tx_valid,
  output logic [7:0]  tx_byte,
  output logic        payload_taken,
  output logic [2:0]  status,
  output logic        crc_selected,
  output logic [7:0]  block_number,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import xbs_pkg::*;

  logic       inq_valid;
  item_t      inq;
  logic       advance;
  logic       fire;
  logic       accept;
  cfg_t       cfg;
  store_req_t req;
  logic [7:0] rd_data;

  assign advance  = !out_valid || !out_stall;
  assign fire     = inq_valid && advance;
  assign in_stall = inq_valid && !advance;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      inq_valid <= 1'b0;
    end else if (accept) begin
      inq_valid <= 1'b1;
    end else if (fire) begin
      inq_valid <= 1'b0;
    end
    if (accept) begin
      inq.kind         <= kind;
      inq.payload_byte <= payload_byte;
      inq.payload_last <= payload_last;
      inq.rx_byte      <= rx_byte;
    end
  end

  xbs_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  xbs_store u_store (
    .clk     (clk),
    .req     (req),
    .rd_data (rd_data)
  );

  xbs_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .fire          (fire),
    .item          (inq),
    .cfg           (cfg),
    .out_stall     (out_stall),
    .rd_data       (rd_data),
    .req           (req),
    .out_valid     (out_valid),
    .tx_valid      (tx_valid),
    .tx_byte       (tx_byte),
    .payload_taken (payload_taken),
    .status        (status),
    .crc_selected  (crc_selected),
    .block_number  (block_number)
  );

endmodule

### hw/rtl/xbs_checker.sv
// Port-level checks for the XMODEM block sender, bound to the top level.
module xbs_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic       tx_valid,
  input logic [7:0] tx_byte,
  input logic       payload_taken,
  input logic [2:0] status
);
  import xbs_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(tx_byte) && $stable(status))
    else $error("stalled result transfer changed");

  a_idle_byte: assert property (@(posedge clk) disable iff (rst)
    out_valid && !tx_valid |-> tx_byte == 8'h00)
    else $error("tx_byte nonzero without tx_valid");

  a_final_sticky: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_BUSY |=> status == $past(status))
    else $error("final status changed before reset");

  a_final_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_BUSY || payload_taken) |-> !tx_valid)
    else $error("byte sent together with a final status or a taken payload");

endmodule

bind xmodem_block_sender xbs_checker u_xbs_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .tx_valid      (tx_valid),
  .tx_byte       (tx_byte),
  .payload_taken (payload_taken),
  .status        (status)
);
